// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL modules.
// They expect signals named clk and rst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/wap_pkg.sv
package wap_pkg;

    localparam int CLASS_COUNT = 8;
    localparam int MAX_WINDOW  = 1024;

    localparam int C_IDX_W = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
    localparam int SLOT_W  = $clog2(MAX_WINDOW);
    localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
    localparam int ADDR_W  = $clog2(CLASS_COUNT * MAX_WINDOW);
    localparam int SUM_W   = CNT_W + 32;
    localparam int DN_W    = CNT_W + 33;
    localparam int DD_W    = CNT_W + 16;
    localparam int WS_W    = 11;
    localparam int AP_W    = 17;

    localparam logic [WS_W-1:0] WS_RESET = 11'd1000;
    localparam logic [AP_W-1:0] AP_ONE   = 17'd65536;

    typedef struct packed {
        logic [2:0]         class_index;
        logic signed [31:0] score;
        logic               label;
        logic               end_of_batch;
    } in_item_t;

    typedef struct packed {
        logic [2:0]      result_class;
        logic [AP_W-1:0] average_precision;
        logic            last;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLS,
        S_RDI,
        S_LATI,
        S_SWP,
        S_SWPL,
        S_DIVT,
        S_DIVW,
        S_NEXTI,
        S_FIN,
        S_FINW,
        S_OUT
    } state_t;

    typedef struct packed {
        logic store;
        logic cls_init;
        logic rd_i;
        logic lat_i;
        logic sw_issue;
        logic div_term;
        logic div_final;
        logic acc_term;
        logic ap_load;
        logic next_i;
        logic out_load;
        logic next_cls;
    } ctl_cmd_t;

    typedef struct packed {
        logic n_zero;
        logic lab_i;
        logic j_last;
        logic i_last;
        logic div_done;
        logic out_full;
        logic cls_last;
    } ctl_sts_t;

    // Ring slot wrap for a sum known to stay below twice the ring size.
    function automatic logic [SLOT_W-1:0] wrap_slot(input logic [CNT_W:0] v);
        logic [CNT_W:0] lim;
        lim = (CNT_W + 1)'(MAX_WINDOW);
        if (v >= lim)
        begin
            return SLOT_W'(v - lim);
        end
        return SLOT_W'(v);
    endfunction

    // Window size as used: zero acts as one, large values clamp.
    function automatic logic [CNT_W-1:0] eff_size(input logic [WS_W-1:0] ws);
        if (ws == '0)
        begin
            return CNT_W'(1);
        end
        if (int'(ws) > MAX_WINDOW)
        begin
            return CNT_W'(MAX_WINDOW);
        end
        return CNT_W'(ws);
    endfunction

endpackage

// File: hw/rtl/wap_div.sv
`include "assert_macros.svh"

module wap_div import wap_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [DN_W-1:0] dividend,
    input  logic [DD_W-1:0] divisor,
    output logic            done,
    output logic [DN_W-1:0] quotient
);

    localparam int CB = $clog2(DN_W + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CB-1:0] cnt_reg;
    logic [DN_W-1:0] q_reg;
    logic [DD_W-1:0] r_reg;
    logic [DD_W-1:0] d_reg;

    logic [DD_W:0]   trial;
    logic            ge;
    logic [DD_W-1:0] r_next;
    logic [DN_W-1:0] q_next;

    always_comb
    begin
        trial  = {r_reg, q_reg[DN_W-1]};
        ge     = trial >= {1'b0, d_reg};
        r_next = ge ? DD_W'(trial - {1'b0, d_reg}) : trial[DD_W-1:0];
        q_next = {q_reg[DN_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CB'(1);
            if (cnt_reg == CB'(DN_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

    `CHK_SAME(start_idle, start, !busy_reg)

endmodule

// File: hw/rtl/wap_datapath.sv
`include "assert_macros.svh"

module wap_datapath import wap_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  in_item_t        in_data,
    input  logic            cfg_we,
    input  logic [WS_W-1:0] cfg_data,
    input  logic            out_ready,
    input  ctl_cmd_t        cmd,
    output ctl_sts_t        sts,
    output out_item_t       out_data,
    output logic            out_valid
);

    logic [32:0] mem [CLASS_COUNT*MAX_WINDOW];

    logic [WS_W-1:0]    ws_reg;
    logic [CNT_W-1:0]   fill_reg [CLASS_COUNT];
    logic [SLOT_W-1:0]  old_reg  [CLASS_COUNT];

    logic [C_IDX_W-1:0] c_reg;
    logic [CNT_W-1:0]   n_reg;
    logic [SLOT_W-1:0]  o_reg;
    logic [SLOT_W-1:0]  i_reg;
    logic [SLOT_W-1:0]  j_reg;
    logic [SLOT_W-1:0]  jd_reg;
    logic               sw_vld_reg;
    logic [31:0]        keyi_reg;
    logic [SLOT_W-1:0]  a_reg;
    logic [SLOT_W-1:0]  p_reg;
    logic [CNT_W-1:0]   pos_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [AP_W-1:0]    ap_reg;
    logic [32:0]        rdata_reg;
    logic               out_valid_reg;
    out_item_t          out_reg;

    logic               in_ok;
    logic [C_IDX_W-1:0] in_c;
    logic [C_IDX_W-1:0] sel_c;
    logic [CNT_W-1:0]   fill_sel;
    logic [SLOT_W-1:0]  old_sel;
    logic [CNT_W-1:0]   lim;
    logic [CNT_W-1:0]   keep;
    logic [CNT_W-1:0]   drop;
    logic [SLOT_W-1:0]  old_new;
    logic [SLOT_W-1:0]  wslot;
    logic [ADDR_W-1:0]  waddr;
    logic [CNT_W-1:0]   cfg_lim;
    logic [SLOT_W-1:0]  ridx;
    logic [SLOT_W-1:0]  rslot;
    logic [ADDR_W-1:0]  raddr;
    logic               ahead;
    logic [CNT_W-1:0]   tp1;
    logic [CNT_W-1:0]   pos1;
    logic [DD_W-1:0]    dfin;
    logic [DN_W-1:0]    div_dividend;
    logic [DD_W-1:0]    div_divisor;
    logic               div_done;
    logic [DN_W-1:0]    div_q;

    always_comb
    begin
        in_ok    = int'(in_data.class_index) < CLASS_COUNT;
        in_c     = C_IDX_W'(in_data.class_index);
        sel_c    = cmd.cls_init ? c_reg : in_c;
        fill_sel = fill_reg[sel_c];
        old_sel  = old_reg[sel_c];
        lim      = eff_size(ws_reg);
        // A full window gives up its oldest entries so the new one fits.
        keep     = (fill_sel >= lim) ? lim - CNT_W'(1) : fill_sel;
        drop     = fill_sel - keep;
        old_new  = wrap_slot((CNT_W + 1)'(old_sel) + (CNT_W + 1)'(drop));
        wslot    = wrap_slot((CNT_W + 1)'(old_new) + (CNT_W + 1)'(keep));
        waddr    = ADDR_W'(in_c) * ADDR_W'(MAX_WINDOW) + ADDR_W'(wslot);
        cfg_lim  = eff_size(cfg_data);

        ridx  = cmd.rd_i ? i_reg : j_reg;
        rslot = wrap_slot((CNT_W + 1)'(o_reg) + (CNT_W + 1)'(ridx));
        raddr = ADDR_W'(c_reg) * ADDR_W'(MAX_WINDOW) + ADDR_W'(rslot);

        // Entry j ranks ahead of entry i on a higher score, or on an equal
        // score when it arrived earlier.
        ahead = ($signed(rdata_reg[31:0]) > $signed(keyi_reg)) ||
                (($signed(rdata_reg[31:0]) == $signed(keyi_reg)) && (jd_reg < i_reg));

        tp1  = CNT_W'(p_reg) + CNT_W'(1);
        pos1 = (pos_reg == '0) ? CNT_W'(1) : pos_reg;
        dfin = DD_W'(pos1) << 16;
        if (cmd.div_final)
        begin
            div_dividend = DN_W'(sum_reg) + DN_W'(dfin >> 1);
            div_divisor  = dfin;
        end
        else
        begin
            div_dividend = DN_W'({tp1, 32'd0});
            div_divisor  = DD_W'(CNT_W'(a_reg) + CNT_W'(1));
        end
    end

    wap_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_term | cmd.div_final),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.store && in_ok)
        begin
            mem[waddr] <= {in_data.label, in_data.score};
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg <= WS_RESET;
            for (int k = 0; k < CLASS_COUNT; k++)
            begin
                fill_reg[k] <= '0;
                old_reg[k]  <= '0;
            end
        end
        else if (cfg_we)
        begin
            ws_reg <= cfg_data;
            for (int k = 0; k < CLASS_COUNT; k++)
            begin
                if (fill_reg[k] > cfg_lim)
                begin
                    fill_reg[k] <= cfg_lim;
                    old_reg[k]  <= wrap_slot((CNT_W + 1)'(old_reg[k]) +
                                             (CNT_W + 1)'(fill_reg[k] - cfg_lim));
                end
            end
        end
        else if (cmd.store && in_ok)
        begin
            fill_reg[in_c] <= keep + CNT_W'(1);
            old_reg[in_c]  <= old_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_reg         <= '0;
            n_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            sw_vld_reg    <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sw_vld_reg <= cmd.sw_issue;
            if (cmd.store)
            begin
                c_reg <= '0;
            end
            else if (cmd.next_cls)
            begin
                c_reg <= c_reg + C_IDX_W'(1);
            end
            if (cmd.cls_init)
            begin
                n_reg   <= fill_sel;
                i_reg   <= '0;
                pos_reg <= '0;
            end
            if (cmd.next_i)
            begin
                i_reg <= i_reg + SLOT_W'(1);
            end
            if (cmd.lat_i)
            begin
                j_reg <= '0;
            end
            else if (cmd.sw_issue)
            begin
                j_reg <= j_reg + SLOT_W'(1);
            end
            if (cmd.acc_term)
            begin
                pos_reg <= pos_reg + CNT_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cls_init)
        begin
            o_reg   <= old_sel;
            sum_reg <= '0;
        end
        jd_reg <= j_reg;
        if (cmd.lat_i)
        begin
            keyi_reg <= rdata_reg[31:0];
            a_reg    <= '0;
            p_reg    <= '0;
        end
        else if (sw_vld_reg && ahead)
        begin
            a_reg <= a_reg + SLOT_W'(1);
            if (rdata_reg[32])
            begin
                p_reg <= p_reg + SLOT_W'(1);
            end
        end
        if (cmd.acc_term)
        begin
            sum_reg <= sum_reg + SUM_W'(div_q);
        end
        if (cmd.ap_load)
        begin
            ap_reg <= AP_W'(div_q);
        end
        if (cmd.out_load)
        begin
            out_reg.result_class      <= 3'(c_reg);
            out_reg.average_precision <= ap_reg;
            out_reg.last              <= (c_reg == C_IDX_W'(CLASS_COUNT - 1));
        end
    end

    always_comb
    begin
        sts.n_zero   = (fill_sel == '0);
        sts.lab_i    = rdata_reg[32];
        sts.j_last   = ({1'b0, j_reg} == n_reg - CNT_W'(1));
        sts.i_last   = ({1'b0, i_reg} == n_reg - CNT_W'(1));
        sts.div_done = div_done;
        sts.out_full = out_valid_reg && !out_ready;
        sts.cls_last = (c_reg == C_IDX_W'(CLASS_COUNT - 1));
    end

    assign out_data  = out_reg;
    assign out_valid = out_valid_reg;

    `CHK_SAME(ap_in_range, cmd.out_load, ap_reg <= AP_ONE)
    `CHK_SAME(pos_bounded, 1'b1, pos_reg <= n_reg)

endmodule

// File: hw/rtl/wap_ctrl.sv
module wap_ctrl import wap_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_eob,
    input  ctl_sts_t sts,
    output logic     in_ready,
    output ctl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.store = in_valid;
                if (in_valid && in_eob)
                begin
                    state_next = S_CLS;
                end
            end
            S_CLS:
            begin
                cmd.cls_init = 1'b1;
                state_next   = sts.n_zero ? S_FIN : S_RDI;
            end
            S_RDI:
            begin
                cmd.rd_i   = 1'b1;
                state_next = S_LATI;
            end
            S_LATI:
            begin
                cmd.lat_i  = 1'b1;
                // Negative entries add no precision term.
                state_next = sts.lab_i ? S_SWP : S_NEXTI;
            end
            S_SWP:
            begin
                cmd.sw_issue = 1'b1;
                if (sts.j_last)
                begin
                    state_next = S_SWPL;
                end
            end
            S_SWPL:
            begin
                state_next = S_DIVT;
            end
            S_DIVT:
            begin
                cmd.div_term = 1'b1;
                state_next   = S_DIVW;
            end
            S_DIVW:
            begin
                if (sts.div_done)
                begin
                    cmd.acc_term = 1'b1;
                    state_next   = S_NEXTI;
                end
            end
            S_NEXTI:
            begin
                if (sts.i_last)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.next_i = 1'b1;
                    state_next = S_RDI;
                end
            end
            S_FIN:
            begin
                cmd.div_final = 1'b1;
                state_next    = S_FINW;
            end
            S_FINW:
            begin
                if (sts.div_done)
                begin
                    cmd.ap_load = 1'b1;
                    state_next  = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!sts.out_full)
                begin
                    cmd.out_load = 1'b1;
                    if (sts.cls_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.next_cls = 1'b1;
                        state_next   = S_CLS;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/windowed_average_precision_core.sv
// Keeps a sliding window of the most recent scored entries for each class
// and, on a transaction flagged end_of_batch, emits the average precision of
// every class in ascending class order, as Q1.16 with last on the final one.
// Entries are stored at one per cycle while the core waits in its idle
// state; the config port is always ready and a smaller window_size trims
// every class at once. At a batch end each class is processed in turn, and
// its result may wait for out_ready: every entry is read once, and for each
// positive entry the single read port of the entry memory sweeps the whole
// window to find its rank, then a one-bit-per-cycle divider (44 steps)
// forms its precision term; a final division gives the average.
// No input is taken until the last result of the batch has been loaded.
module windowed_average_precision_core import wap_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  in_item_t        in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output out_item_t       out_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [WS_W-1:0] cfg_data
);

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    assign cfg_ready = 1'b1;

    wap_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_eob   (in_data.end_of_batch),
        .sts      (sts),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    wap_datapath u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_valid),
        .cfg_data  (cfg_data),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts),
        .out_data  (out_data),
        .out_valid (out_valid)
    );

endmodule
